>>> src/hsdf_pkg.sv
// ----------------------------------------------------------------------------
// hsdf_pkg
// Shared sizes, tokens and state codes of the hash-set duplicate filter.
// ----------------------------------------------------------------------------
package hsdf_pkg;

    // BUCKETS must be a power of two: the row is the low bits of the magnitude.
    localparam int BUCKETS   = 1024;
    localparam int WAYS      = 4;
    localparam int ROW_W     = $clog2(BUCKETS);
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(BUCKETS - 1);

    // Request travelling along the row of way cells.
    typedef struct packed {
        logic              vld;
        logic [DATA_W-1:0] value;
        logic [ROW_W-1:0]  row;
        logic              last;
        logic              hit;
        logic              free_found;
        logic [WAY_W-1:0]  free_way;
    } t_tok;

    // Insertion of a new value into one way of one row.
    typedef struct packed {
        logic              en;
        logic [WAY_W-1:0]  way;
        logic [ROW_W-1:0]  row;
        logic [DATA_W-1:0] value;
    } t_commit;

    // Clearing sweep over the valid bits.
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr;
    } t_clr;

    typedef struct packed {
        logic [DATA_W-1:0]  value;
        logic               keep;
        logic               overflow;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_res;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } t_state;

endpackage

>>> src/hsdf_cell.sv
// ----------------------------------------------------------------------------
// hsdf_cell
// One way of the hash set: stores that way of every row and checks a request.
// ----------------------------------------------------------------------------
module hsdf_cell import hsdf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [WAY_W-1:0] i_way,
    input  t_tok             i_tok,
    input  t_commit          i_commit,
    input  t_clr             i_clr,
    output t_tok             o_tok
);

    logic [DATA_W-1:0] r_val_mem [BUCKETS];
    logic              r_vld_mem [BUCKETS];
    logic [DATA_W-1:0] r_rd_val;
    logic              r_rd_vld;
    t_tok              r_tok;

    // The row is read as the request is taken in, so both line up next cycle.
    always_ff @(posedge i_clk) begin
        if (i_tok.vld) begin
            r_rd_val <= r_val_mem[i_tok.row];
            r_rd_vld <= r_vld_mem[i_tok.row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clr.en) begin
            r_vld_mem[i_clr.addr] <= 1'b0;
        end else if (i_commit.en && (i_commit.way == i_way)) begin
            r_val_mem[i_commit.row] <= i_commit.value;
            r_vld_mem[i_commit.row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_comb begin
        o_tok = r_tok;
        if (r_rd_vld && (r_rd_val == r_tok.value)) begin
            o_tok.hit = 1'b1;
        end
        // Earlier ways have already claimed the lowest free slot, if any.
        if (!r_rd_vld && !r_tok.free_found) begin
            o_tok.free_found = 1'b1;
            o_tok.free_way   = i_way;
        end
    end

endmodule

>>> src/hsdf_outq.sv
// ----------------------------------------------------------------------------
// hsdf_outq
// Two-entry result queue that parts the filter from the downstream stall.
// ----------------------------------------------------------------------------
module hsdf_outq import hsdf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    input  logic i_stall,
    output logic o_valid,
    output t_res o_res,
    output logic o_room
);

    t_res       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && !i_stall;
    assign o_res   = r_ent[r_rp];
    assign o_room  = (r_cnt != 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> src/hash_set_duplicate_filter.sv
// ----------------------------------------------------------------------------
// hash_set_duplicate_filter
// Batch de-duplication of signed values through a row of way cells.
// ----------------------------------------------------------------------------
// One request is in flight at a time. It walks through the WAYS way cells, one
// cell a cycle, each cell reading its own memory at the row and comparing. When
// the last cell presents its output the result is queued and a new value written
// into the lowest free way; the next request is taken only after that. After
// reset, and after every request marked last, the valid bits are swept clear
// one row a cycle, which holds off input until the last row is cleared. Results
// wait in a two-entry queue, so a stalled output holds up the next request only
// once the queue is full.
module hash_set_duplicate_filter import hsdf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_last,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_value_out,
    output logic                     o_keep,
    output logic                     o_overflow,
    output logic [COUNT_W-1:0]       o_unique_count,
    output logic                     o_last_out
);

    t_state             r_state, n_state;
    logic [ROW_W-1:0]   r_clr_addr, n_clr_addr;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               w_room;
    logic               w_accept;
    logic [DATA_W-1:0]  w_mag;
    t_tok               w_tok [WAYS+1];
    t_tok               w_end;
    t_commit            w_commit;
    t_clr               w_clr;
    t_res               w_res;
    t_res               w_qres;
    logic               w_keep;

    assign w_accept = i_valid && !o_stall;

    // The low bits of the magnitude depend only on the low bits of the value.
    assign w_mag = i_value[DATA_W-1] ? (~$unsigned(i_value) + 32'd1) : $unsigned(i_value);

    always_comb begin
        w_tok[0]            = '0;
        w_tok[0].vld        = w_accept;
        w_tok[0].value      = $unsigned(i_value);
        w_tok[0].row        = w_mag[ROW_W-1:0];
        w_tok[0].last       = i_last;
    end

    assign w_clr.en   = (r_state == ST_CLEAR);
    assign w_clr.addr = r_clr_addr;

    for (genvar g = 0; g < WAYS; g++) begin : g_way
        hsdf_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_way    (WAY_W'(g)),
            .i_tok    (w_tok[g]),
            .i_commit (w_commit),
            .i_clr    (w_clr),
            .o_tok    (w_tok[g+1])
        );
    end

    assign w_end  = w_tok[WAYS];
    assign w_keep = !w_end.hit;

    always_comb begin
        w_commit.en    = w_end.vld && w_keep && w_end.free_found;
        w_commit.way   = w_end.free_way;
        w_commit.row   = w_end.row;
        w_commit.value = w_end.value;
    end

    always_comb begin
        n_count = r_count;
        if (w_keep && (r_count != COUNT_MAX)) begin
            n_count = r_count + 13'd1;
        end
        w_res.value    = w_end.value;
        w_res.keep     = w_keep;
        w_res.overflow = w_keep && !w_end.free_found;
        w_res.count    = n_count;
        w_res.last     = w_end.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_end.vld) begin
            r_count <= w_end.last ? '0 : n_count;
        end
    end

    hsdf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_end.vld),
        .i_res   (w_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (w_qres),
        .o_room  (w_room)
    );

    assign o_value_out    = $signed(w_qres.value);
    assign o_keep         = w_qres.keep;
    assign o_overflow     = w_qres.overflow;
    assign o_unique_count = w_qres.count;
    assign o_last_out     = w_qres.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        o_stall    = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + ROW_W'(1);
                if (r_clr_addr == ROW_LAST) begin
                    n_state    = ST_IDLE;
                    n_clr_addr = '0;
                end
            end
            ST_IDLE: begin
                o_stall = !w_room;
                if (i_valid && w_room) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (w_end.vld) begin
                    n_state = w_end.last ? ST_CLEAR : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

>>> tb/hash_set_duplicate_filter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hash_set_duplicate_filter_test
// Self-checking bench for the hash-set duplicate filter. Batches of values are
// sent through the request channel. A local model of the set predicts every
// result: keep, overflow, running count and the passed-through fields. Each
// result is checked in order against the oldest prediction. Sender gaps and
// receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module hash_set_duplicate_filter_test;
    import hsdf_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [DATA_W-1:0] i_value;
    logic                     i_last;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [DATA_W-1:0] o_value_out;
    logic                     o_keep;
    logic                     o_overflow;
    logic [COUNT_W-1:0]       o_unique_count;
    logic                     o_last_out;

    hash_set_duplicate_filter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_value_out    (o_value_out),
        .o_keep         (o_keep),
        .o_overflow     (o_overflow),
        .o_unique_count (o_unique_count),
        .o_last_out     (o_last_out)
    );

    // Local copy of the set: valid bits and stored values per row.
    logic [WAYS-1:0]    row_valid [BUCKETS];
    logic [DATA_W-1:0]  row_entry [BUCKETS][WAYS];
    logic [COUNT_W-1:0] kept_count;

    t_res pending_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int requests_sent  = 0;
    int batches_sent   = 0;
    int kept_total     = 0;
    int overflow_total = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic void clear_filter_set();
        for (int r = 0; r < BUCKETS; r++) begin
            row_valid[r] = '0;
        end
        kept_count = '0;
    endfunction

    function automatic t_res predict_filter(input logic [DATA_W-1:0] v,
                                            input logic lst);
        logic [DATA_W-1:0] mag;
        logic [ROW_W-1:0]  row;
        logic              hit;
        int                free_way;
        t_res              res;
        mag      = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
        row      = mag[ROW_W-1:0];
        hit      = 1'b0;
        free_way = -1;
        for (int w = 0; w < WAYS; w++) begin
            if (row_valid[row][w]) begin
                if (row_entry[row][w] == v) hit = 1'b1;
            end else if (free_way < 0) begin
                free_way = w;
            end
        end
        res.value    = v;
        res.keep     = !hit;
        res.overflow = 1'b0;
        res.last     = lst;
        if (!hit) begin
            if (free_way >= 0) begin
                row_entry[row][free_way] = v;
                row_valid[row][free_way] = 1'b1;
            end else begin
                res.overflow = 1'b1;
            end
            if (kept_count != COUNT_MAX) kept_count = kept_count + COUNT_W'(1);
        end
        res.count = kept_count;
        // The set is emptied only after the last request's result is formed.
        if (lst) clear_filter_set();
        return res;
    endfunction

    // Presents one request and holds it until the filter takes it.
    task automatic send_value(input logic [DATA_W-1:0] v, input logic lst);
        t_res exp_res;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        i_last  <= lst;
        do @(posedge i_clk); while (o_stall);
        exp_res = predict_filter(v, lst);
        pending_results.push_back(exp_res);
        requests_sent++;
        kept_total     += exp_res.keep;
        overflow_total += exp_res.overflow;
        if (lst) batches_sent++;
    endtask

    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] unexpected: value %h keep %b ovf %b count %0d last %b",
                             $realtime, o_value_out, o_keep, o_overflow,
                             o_unique_count, o_last_out);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_value_out !== exp_res.value || o_keep !== exp_res.keep ||
                    o_overflow !== exp_res.overflow || o_unique_count !== exp_res.count ||
                    o_last_out !== exp_res.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("[%0t] expected: value %h keep %b ovf %b count %0d last %b",
                                 $realtime, exp_res.value, exp_res.keep,
                                 exp_res.overflow, exp_res.count, exp_res.last);
                        $display("[%0t] actual:   value %h keep %b ovf %b count %0d last %b",
                                 $realtime, o_value_out, o_keep, o_overflow,
                                 o_unique_count, o_last_out);
                    end
                end
            end
        end
    end

    // Extreme values, repeats, a full row, sign pairs sharing a row and batch ends.
    task automatic test_directed_extremes();
        logic [DATA_W-1:0] vals [18];
        logic              lasts [18];
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        vals = '{32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0400,
                 32'hFFFF_FC00, 32'hFFFF_FC00, 32'h0000_0000, 32'h0000_0001,
                 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFF,
                 32'hFFFF_FFFF, 32'h0000_0001,
                 32'h0000_0000, 32'h0000_0000,
                 32'h8000_0000, 32'h7FFF_FFFF};
        lasts = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                  0, 1,
                  1, 1};
        for (int k = 0; k < 18; k++) begin
            send_value(vals[k], lasts[k]);
        end
    endtask

    // Whole batches with repeats from a small pool, crowding into one row, and
    // fully random values.
    task automatic test_random_batches(input int n_items, input int idle_pct,
                                       input int stall_pct);
        logic [DATA_W-1:0] pool [8];
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] mag;
        logic [ROW_W-1:0]  hot_row;
        int                batch_len;
        int                sent;
        int                pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            batch_len = $urandom_range(40, 1);
            hot_row   = ROW_W'($urandom_range(BUCKETS - 1));
            for (int k = 0; k < 8; k++) begin
                pool[k] = $urandom;
            end
            for (int k = 0; k < batch_len; k++) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    v = pool[$urandom_range(7)];
                end else if (pick < 70) begin
                    mag = (DATA_W'($urandom_range(5)) << ROW_W) | DATA_W'(hot_row);
                    v   = $urandom_range(1) ? (~mag + DATA_W'(1)) : mag;
                end else if (pick < 95) begin
                    v = $urandom;
                end else begin
                    case ($urandom_range(3))
                        0: v = 32'h8000_0000;
                        1: v = 32'h7FFF_FFFF;
                        2: v = 32'h0000_0000;
                        default: v = 32'hFFFF_FFFF;
                    endcase
                end
                send_value(v, k == batch_len - 1);
                sent++;
            end
        end
    endtask

    // One batch aimed at a single row: sixteen distinct values fill it and
    // overflow, then the same sixteen again, where only the stored ones repeat.
    task automatic test_full_row_overflow();
        int n;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        n = 32;
        for (int k = 0; k < n; k++) begin
            send_value(DATA_W'(k & 15) << ROW_W, k == n - 1);
        end
    endtask

    initial begin
        int guard;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        i_last  = 1'b0;
        clear_filter_set();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        test_random_batches(190, 0, 0);
        test_random_batches(190, 46, 0);
        test_random_batches(190, 0, 46);
        test_random_batches(190, 37, 37);
        test_full_row_overflow();

        @(negedge i_clk);
        i_valid <= 1'b0;
        recv_stall_pct = 20;
        guard = 0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4 * (WAYS + 1)) @(posedge i_clk);

        $display("Sent %0d requests in %0d batches: %0d kept, %0d overflowed a full row.",
                 requests_sent, batches_sent, kept_total, overflow_total);
        $display("%0d mismatches, %0d results never arrived.",
                 mismatch_count, pending_results.size());
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
